>>> src/pfrs_pkg.sv
package pfrs_pkg;

	localparam int COLUMNS = 128;
	localparam int PAGES   = 8;
	localparam int ROWS    = PAGES * 8;
	localparam int HEADER  = 3;
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;
	localparam int BIT_W   = $clog2(ROWS);
	localparam int STEP_W  = $clog2(HEADER + COLUMNS);

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	typedef logic [COL_W-1:0]  col_t;
	typedef logic [PAGE_W-1:0] page_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [ROWS-1:0]   word_t;

	typedef enum logic [2:0] {
		OP_DRAW    = 3'd0,
		OP_FILL    = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_REFRESH = 3'd3,
		OP_TICK    = 3'd4
	} op_t;

	typedef struct packed {
		logic  en;
		col_t  addr;
		word_t data;
	} mem_wr_t;

	typedef struct packed {
		logic en;
		col_t addr;
	} mem_rd_t;

endpackage

>>> src/pfrs_in_if.sv
interface pfrs_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] column;
	logic [7:0] row;
	logic [7:0] column_end;
	logic [7:0] row_end;
	logic       pixel_on;

	modport source (output valid, operation, column, row, column_end, row_end, pixel_on,
		input ready);
	modport sink (input valid, operation, column, row, column_end, row_end, pixel_on,
		output ready);
endinterface

>>> src/pfrs_out_if.sv
interface pfrs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_data;
	logic       last;

	modport source (output valid, out_byte, is_data, last, input ready);
	modport sink (input valid, out_byte, is_data, last, output ready);
endinterface

>>> src/pfrs_frame_store.sv
module pfrs_frame_store
	import pfrs_pkg::*;
(
	input  logic    clk,
	input  mem_wr_t wr,
	input  mem_rd_t rd,
	output word_t   rd_data
);

	// One word per column; bit ROWS-1-y of a word holds pixel row y.
	word_t mem_q [COLUMNS];
	word_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/page_framebuffer_refresh_streamer.sv
// Channel  Modport  Word
// cmd      sink     operation, column, row, column_end, row_end, pixel_on
// disp     source   out_byte, is_data, last
//
// A draw and a tick during a refresh each read the column word, then do its write-back or the
// output register load. Fill reads and writes back each column in the rectangle in turn, an
// empty rectangle touches nothing, and clear writes every column word. The frame store has
// one column word per cycle of bandwidth.
// After reset a clearing pass writes every column word before the first word is taken.
// No word is taken while the output register holds a word that is not being emptied.
module page_framebuffer_refresh_streamer
	import pfrs_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	pfrs_in_if.sink     cmd,
	pfrs_out_if.source  disp
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CLEAR = 3'b010,
		ST_FILL  = 3'b100
	} state_t;

	state_t  state_q;
	col_t    clr_q;
	col_t    fill_col_q;
	col_t    fill_end_q;
	word_t   fill_mask_q;
	logic    fill_on_q;

	logic    wb_valid_s1;
	col_t    wb_addr_s1;
	word_t   wb_mask_s1;
	logic    wb_on_s1;

	logic    tick_s1;
	logic [7:0] tick_byte_s1;
	logic    tick_data_s1;
	logic    tick_last_s1;
	page_t   tick_page_s1;

	logic    refresh_active_q;
	page_t   refresh_page_q;
	step_t   refresh_step_q;

	logic    out_valid_q;
	logic [7:0] out_byte_q;
	logic    out_data_q;
	logic    out_last_q;

	mem_wr_t wr;
	mem_rd_t rd;
	word_t   rd_data;

	logic       in_ready;
	logic       in_acc;
	logic [7:0] x_end_c;
	logic [7:0] y_end_c;
	word_t      fill_mask;
	word_t      draw_mask;
	logic       draw_hit;
	logic       fill_go;
	logic       step_last;
	logic       page_last;
	logic [7:0] hdr_byte;

	pfrs_frame_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	assign in_ready = (state_q == ST_IDLE) && !wb_valid_s1 && !tick_s1
		&& (!out_valid_q || disp.ready);
	assign cmd.ready = in_ready;
	assign in_acc = cmd.valid && in_ready;

	assign x_end_c = (cmd.column_end > 8'(COLUMNS - 1)) ? 8'(COLUMNS - 1) : cmd.column_end;
	assign y_end_c = (cmd.row_end > 8'(ROWS - 1)) ? 8'(ROWS - 1) : cmd.row_end;
	assign draw_hit = 9'(cmd.column) < 9'(COLUMNS);

	always_comb begin
		logic [7:0] y_i;
		y_i = '0;
		for (int i = 0; i < ROWS; i++) begin
			y_i = 8'(ROWS - 1 - i);
			fill_mask[i] = (y_i >= cmd.row) && (y_i <= y_end_c);
			draw_mask[i] = (y_i == cmd.row);
		end
	end

	// An empty rectangle touches nothing but still starts the refresh.
	assign fill_go = (cmd.column <= x_end_c) && (|fill_mask);

	assign step_last = refresh_step_q == STEP_W'(HEADER + COLUMNS - 1);
	assign page_last = refresh_page_q == PAGE_W'(PAGES - 1);

	always_comb begin
		case (refresh_step_q)
			STEP_W'(0): hdr_byte = CMD_PAGE_BASE + 8'(refresh_page_q);
			STEP_W'(1): hdr_byte = CMD_COL_LOW;
			STEP_W'(2): hdr_byte = CMD_COL_HIGH;
			default:    hdr_byte = '0;
		endcase
	end

	always_comb begin
		rd.en   = 1'b0;
		rd.addr = '0;
		if (state_q == ST_FILL) begin
			rd.en   = 1'b1;
			rd.addr = fill_col_q;
		end else if (in_acc && cmd.operation == OP_DRAW) begin
			rd.en   = 1'b1;
			rd.addr = cmd.column[COL_W-1:0];
		end else if (in_acc && cmd.operation == OP_TICK) begin
			rd.en   = refresh_active_q;
			rd.addr = COL_W'(refresh_step_q - STEP_W'(HEADER));
		end
	end

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = '0;
		wr.data = '0;
		if (state_q == ST_CLEAR) begin
			wr.en   = 1'b1;
			wr.addr = clr_q;
		end else if (wb_valid_s1) begin
			wr.en   = 1'b1;
			wr.addr = wb_addr_s1;
			wr.data = wb_on_s1 ? (rd_data | wb_mask_s1) : (rd_data & ~wb_mask_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_CLEAR;
			clr_q            <= '0;
			fill_col_q       <= '0;
			wb_valid_s1      <= 1'b0;
			tick_s1          <= 1'b0;
			refresh_active_q <= 1'b0;
			refresh_page_q   <= '0;
			refresh_step_q   <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			wb_valid_s1 <= 1'b0;
			tick_s1     <= 1'b0;

			if (tick_s1) begin
				out_valid_q <= 1'b1;
			end else if (disp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == COL_W'(COLUMNS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FILL: begin
					wb_valid_s1 <= 1'b1;
					fill_col_q  <= fill_col_q + 1'b1;
					if (fill_col_q == fill_end_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (cmd.operation)
							OP_DRAW: begin
								wb_valid_s1 <= 1'b1;
							end
							OP_FILL: begin
								if (fill_go) begin
									state_q    <= ST_FILL;
									fill_col_q <= cmd.column[COL_W-1:0];
								end
							end
							OP_CLEAR: begin
								state_q <= ST_CLEAR;
								clr_q   <= '0;
							end
							OP_TICK: begin
								if (refresh_active_q) begin
									tick_s1 <= 1'b1;
									if (step_last) begin
										refresh_step_q <= '0;
										if (page_last) begin
											refresh_active_q <= 1'b0;
											refresh_page_q   <= '0;
										end else begin
											refresh_page_q <= refresh_page_q + 1'b1;
										end
									end else begin
										refresh_step_q <= refresh_step_q + 1'b1;
									end
								end
							end
							default: begin
							end
						endcase
						if (cmd.operation == OP_FILL || cmd.operation == OP_CLEAR
							|| cmd.operation == OP_REFRESH) begin
							refresh_active_q <= 1'b1;
							refresh_page_q   <= '0;
							refresh_step_q   <= '0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FILL) begin
			wb_addr_s1 <= fill_col_q;
			wb_mask_s1 <= fill_mask_q;
			wb_on_s1   <= fill_on_q;
		end else if (in_acc && cmd.operation == OP_DRAW) begin
			wb_addr_s1 <= cmd.column[COL_W-1:0];
			wb_mask_s1 <= draw_hit ? draw_mask : '0;
			wb_on_s1   <= cmd.pixel_on;
		end
		if (in_acc && cmd.operation == OP_FILL) begin
			fill_end_q  <= x_end_c[COL_W-1:0];
			fill_mask_q <= fill_mask;
			fill_on_q   <= cmd.pixel_on;
		end
		if (in_acc && cmd.operation == OP_TICK) begin
			tick_byte_s1 <= hdr_byte;
			tick_data_s1 <= refresh_step_q >= STEP_W'(HEADER);
			tick_last_s1 <= step_last && page_last;
			tick_page_s1 <= refresh_page_q;
		end
		if (tick_s1) begin
			out_byte_q <= tick_data_s1 ? rd_data[BIT_W'({tick_page_s1, 3'b000}) +: 8]
				: tick_byte_s1;
			out_data_q <= tick_data_s1;
			out_last_q <= tick_last_s1;
		end
	end

	assign disp.valid    = out_valid_q;
	assign disp.out_byte = out_byte_q;
	assign disp.is_data  = out_data_q;
	assign disp.last     = out_last_q;

endmodule

>>> src/pfrs_checker.sv
module pfrs_checker
	import pfrs_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [2:0] in_operation,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       is_data,
	input logic       last
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output word changed while stalled");

	a_last_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> is_data)
		else $error("last flag on a command byte");

	a_out_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_acc && in_operation == OP_TICK, 2))
		else $error("output word without a tick two cycles before");

	a_draw_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (in_operation == OP_DRAW || in_operation == OP_CLEAR) |=> !in_ready)
		else $error("word taken during a frame store write-back");

endmodule

bind page_framebuffer_refresh_streamer pfrs_checker u_pfrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (cmd.valid),
	.in_ready     (cmd.ready),
	.in_operation (cmd.operation),
	.out_valid    (disp.valid),
	.out_ready    (disp.ready),
	.out_byte     (disp.out_byte),
	.is_data      (disp.is_data),
	.last         (disp.last)
);

>>> sim/tb_page_framebuffer_refresh_streamer.sv
module tb_page_framebuffer_refresh_streamer;
	timeunit 1ns;
	timeprecision 1ps;

	import pfrs_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int FRAME_TICKS = PAGES * (HEADER + COLUMNS);
	localparam logic [2:0] FIRST_UNUSED_OP = OP_TICK + 3'd1;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] column;
		logic [7:0] row;
		logic [7:0] column_end;
		logic [7:0] row_end;
		logic       pixel_on;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_data;
		logic       last;
	} disp_word_t;

	logic clk = 1'b0;
	logic arst_n;

	pfrs_in_if  cmd ();
	pfrs_out_if disp ();

	page_framebuffer_refresh_streamer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.disp   (disp.source)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Shadow of the frame store and of the refresh position.
	logic [7:0] frame_model [COLUMNS][PAGES];
	bit         refreshing;
	int         cur_page;
	int         cur_step;

	cmd_word_t  cmd_backlog [$];
	disp_word_t pending_bytes [$];
	cmd_word_t  cmd_cur;

	int words_queued;
	int words_accepted;
	int bytes_checked;
	int frames_seen;
	int mismatches;
	int cycle_count;
	int tx_idle_pct;
	int rx_idle_pct;
	int op_counts [8];

	function automatic void plot_pixel(int x, int y, logic on);
		int page;
		if (x >= COLUMNS || y >= ROWS)
			return;
		page = PAGES - 1 - y / 8;
		frame_model[x][page][7 - y % 8] = on;
	endfunction

	function automatic void advance_frame_model(cmd_word_t c);
		int         x2;
		int         y2;
		disp_word_t w;
		op_counts[c.operation]++;
		case (c.operation)
			OP_DRAW: begin
				plot_pixel(c.column, c.row, c.pixel_on);
			end
			OP_FILL: begin
				x2 = (c.column_end > COLUMNS - 1) ? COLUMNS - 1 : c.column_end;
				y2 = (c.row_end > ROWS - 1) ? ROWS - 1 : c.row_end;
				for (int x = c.column; x <= x2; x++)
					for (int y = c.row; y <= y2; y++)
						plot_pixel(x, y, c.pixel_on);
				refreshing = 1'b1;
				cur_page = 0;
				cur_step = 0;
			end
			OP_CLEAR: begin
				foreach (frame_model[x, p])
					frame_model[x][p] = 8'h00;
				refreshing = 1'b1;
				cur_page = 0;
				cur_step = 0;
			end
			OP_REFRESH: begin
				refreshing = 1'b1;
				cur_page = 0;
				cur_step = 0;
			end
			OP_TICK: begin
				if (refreshing) begin
					w = '0;
					if (cur_step == 0)
						w.out_byte = CMD_PAGE_BASE + 8'(cur_page);
					else if (cur_step == 1)
						w.out_byte = CMD_COL_LOW;
					else if (cur_step == 2)
						w.out_byte = CMD_COL_HIGH;
					else begin
						w.out_byte = frame_model[cur_step - HEADER][cur_page];
						w.is_data = 1'b1;
					end
					if (cur_step >= HEADER + COLUMNS - 1) begin
						cur_step = 0;
						if (cur_page >= PAGES - 1) begin
							w.last = 1'b1;
							refreshing = 1'b0;
							cur_page = 0;
						end else begin
							cur_page++;
						end
					end else begin
						cur_step++;
					end
					pending_bytes.push_back(w);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void queue_command(logic [2:0] op, int x, int y, int x2, int y2,
		logic on);
		cmd_word_t c;
		c.operation = op;
		c.column = 8'(x);
		c.row = 8'(y);
		c.column_end = 8'(x2);
		c.row_end = 8'(y2);
		c.pixel_on = on;
		cmd_backlog.push_back(c);
		words_queued++;
	endfunction

	function automatic void queue_tick();
		queue_command(OP_TICK, $urandom_range(255), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
	endfunction

	function automatic void queue_unused_op();
		queue_command(FIRST_UNUSED_OP + 3'($urandom_range(2)), $urandom_range(255),
			$urandom_range(255), $urandom_range(255), $urandom_range(255),
			1'($urandom_range(1)));
	endfunction

	// Mostly on-screen pixels; now and then anything the fields can hold.
	function automatic void queue_random_draw();
		int x;
		int y;
		x = ($urandom_range(99) < 85) ? $urandom_range(COLUMNS - 1) : $urandom_range(255);
		y = ($urandom_range(99) < 85) ? $urandom_range(ROWS - 1) : $urandom_range(255);
		queue_command(OP_DRAW, x, y, $urandom_range(255), $urandom_range(255),
			1'($urandom_range(1)));
	endfunction

	function automatic void queue_frame_start();
		int sel;
		int x1;
		int y1;
		sel = $urandom_range(99);
		if (sel < 50) begin
			if ($urandom_range(99) < 80) begin
				x1 = $urandom_range(COLUMNS - 1);
				y1 = $urandom_range(ROWS - 1);
				queue_command(OP_FILL, x1, y1, x1 + $urandom_range(24),
					y1 + $urandom_range(20), 1'($urandom_range(1)));
			end else begin
				queue_command(OP_FILL, $urandom_range(255), $urandom_range(255),
					$urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
			end
		end else if (sel < 85) begin
			queue_command(OP_REFRESH, $urandom_range(255), $urandom_range(255),
				$urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
		end else begin
			queue_command(OP_CLEAR, $urandom_range(255), $urandom_range(255),
				$urandom_range(255), $urandom_range(255), 1'($urandom_range(1)));
		end
	endfunction

	// A refresh start followed by a run of ticks, with pixel writes and unused codes mixed into the stream.
	function automatic void queue_frame_run(int ticks, int draw_pct);
		queue_frame_start();
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(99) < draw_pct)
				queue_random_draw();
			if ($urandom_range(99) < 2)
				queue_unused_op();
			queue_tick();
		end
	endfunction

	function automatic void queue_random_phase(int budget);
		int first;
		int ticks;
		first = words_queued;
		while (words_queued - first < budget) begin
			ticks = $urandom_range(1) ? $urandom_range(24, 1) : $urandom_range(170, 100);
			queue_frame_run(ticks, 10);
			if ($urandom_range(3) == 0)
				for (int k = $urandom_range(4, 1); k > 0; k--)
					case ($urandom_range(2))
						0: queue_unused_op();
						1: queue_random_draw();
						default: queue_tick();
					endcase
		end
	endfunction

	function automatic void queue_directed();
		queue_tick();
		queue_command(FIRST_UNUSED_OP, 255, 255, 255, 255, 1'b1);
		queue_command(FIRST_UNUSED_OP + 3'd2, 0, 0, 0, 0, 1'b0);
		queue_command(OP_DRAW, 0, 0, 0, 0, 1'b1);
		queue_command(OP_DRAW, COLUMNS - 1, ROWS - 1, 0, 0, 1'b1);
		queue_command(OP_DRAW, COLUMNS, 5, 0, 0, 1'b1);
		queue_command(OP_DRAW, 5, ROWS, 0, 0, 1'b1);
		queue_command(OP_DRAW, 255, 255, 255, 255, 1'b1);
		queue_command(OP_DRAW, COLUMNS - 1, ROWS - 1, 0, 0, 1'b0);
		queue_command(OP_FILL, 120, 0, 255, 255, 1'b1);
		repeat (6) queue_tick();
		// Start beyond end: nothing drawn, but the stream restarts.
		queue_command(OP_FILL, 10, 10, 5, 5, 1'b1);
		queue_command(OP_FILL, 122, 8, 125, 20, 1'b0);
		queue_command(OP_REFRESH, 0, 0, 0, 0, 1'b0);
		queue_command(OP_CLEAR, 0, 0, 0, 0, 1'b0);
		repeat (4) queue_tick();
		// Lands in page 0 of column 1, which the next tick sends.
		queue_command(OP_DRAW, 1, 60, 0, 0, 1'b1);
		queue_tick();
	endfunction

	function automatic void note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	function automatic void check_display_word(disp_word_t got);
		disp_word_t want;
		if (pending_bytes.size() == 0) begin
			note_mismatch($sformatf("unexpected word byte=%h is_data=%b last=%b",
				got.out_byte, got.is_data, got.last));
			return;
		end
		want = pending_bytes.pop_front();
		bytes_checked++;
		if (got.last)
			frames_seen++;
		if (got.out_byte !== want.out_byte || got.is_data !== want.is_data
			|| got.last !== want.last)
			note_mismatch($sformatf(
				"word %0d expected byte=%h is_data=%b last=%b, got byte=%h is_data=%b last=%b",
				bytes_checked, want.out_byte, want.is_data, want.last,
				got.out_byte, got.is_data, got.last));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd.valid <= 1'b0;
			cmd.operation <= OP_DRAW;
			cmd.column <= '0;
			cmd.row <= '0;
			cmd.column_end <= '0;
			cmd.row_end <= '0;
			cmd.pixel_on <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				advance_frame_model(cmd_cur);
				words_accepted++;
			end
			if (!cmd.valid || cmd.ready) begin
				if (cmd_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					cmd_cur = cmd_backlog.pop_front();
					cmd.valid <= 1'b1;
					cmd.operation <= cmd_cur.operation;
					cmd.column <= cmd_cur.column;
					cmd.row <= cmd_cur.row;
					cmd.column_end <= cmd_cur.column_end;
					cmd.row_end <= cmd_cur.row_end;
					cmd.pixel_on <= cmd_cur.pixel_on;
				end else begin
					cmd.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disp.ready <= 1'b0;
		end else begin
			if (disp.valid && disp.ready)
				check_display_word({disp.out_byte, disp.is_data, disp.last});
			disp.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic wait_drained();
		while (words_accepted != words_queued || pending_bytes.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		cmd.valid = 1'b0;
		cmd.operation = OP_DRAW;
		cmd.column = '0;
		cmd.row = '0;
		cmd.column_end = '0;
		cmd.row_end = '0;
		cmd.pixel_on = 1'b0;
		disp.ready = 1'b0;
		arst_n = 1'b0;
		foreach (frame_model[x, p])
			frame_model[x][p] = 8'h00;

		tx_idle_pct = 9;
		rx_idle_pct = 86;
		queue_directed();
		// One uninterrupted frame so every page and the final byte are seen.
		queue_frame_run(FRAME_TICKS + 4, 5);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait_drained();

		tx_idle_pct = 86;
		rx_idle_pct = 9;
		queue_random_phase(90);
		wait_drained();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random_phase(90);
		wait_drained();

		repeat (2 * COLUMNS + 16) @(posedge clk);

		$display("Sent %0d commands: %0d draws, %0d fills, %0d clears, %0d refreshes, %0d ticks",
			words_accepted, op_counts[OP_DRAW], op_counts[OP_FILL], op_counts[OP_CLEAR],
			op_counts[OP_REFRESH], op_counts[OP_TICK]);
		$display("Checked %0d display bytes, %0d complete frames, %0d mismatches",
			bytes_checked, frames_seen, mismatches);
		if (mismatches == 0 && pending_bytes.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

>>> page_framebuffer_refresh_streamer.f
src/pfrs_pkg.sv
src/pfrs_in_if.sv
src/pfrs_out_if.sv
src/pfrs_frame_store.sv
src/page_framebuffer_refresh_streamer.sv
src/pfrs_checker.sv
sim/tb_page_framebuffer_refresh_streamer.sv
